FILE: rtl/core/plfr_pkg.sv
// Package for the preamble/length frame receiver.
// Holds sizes, codes and small helpers; no dependencies.
package plfr_pkg;

   localparam int SLOT_COUNT     = 8;
   localparam int SLOT_BYTES     = 256;
   localparam int PREAMBLE_BYTES = 3;

   localparam int SLOT_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int OFFS_W   = $clog2(SLOT_BYTES);
   localparam int STORE_DEPTH = SLOT_COUNT * SLOT_BYTES;
   localparam int STORE_AW = SLOT_W + OFFS_W;
   localparam int MATCH_W  = $clog2(PREAMBLE_BYTES + 2);

   // match counter phases beyond the preamble positions
   localparam logic [MATCH_W-1:0] MATCH_LEN  = MATCH_W'(PREAMBLE_BYTES);
   localparam logic [MATCH_W-1:0] MATCH_BODY = MATCH_W'(PREAMBLE_BYTES + 1);

   localparam logic [7:0] PREAMBLE_RESET = 8'd35;
   localparam logic [7:0] END_RESET      = 8'd33;

   typedef enum logic [1:0] {
      ACT_RECEIVE = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_READ    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_INCOMING = 3'd1,
      ST_ERROR    = 3'd2,
      ST_NEW      = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   localparam logic CSR_PREAMBLE = 1'b0;
   localparam logic CSR_END      = 1'b1;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      if (s == SLOT_W'(SLOT_COUNT - 1)) begin
         return '0;
      end
      return s + SLOT_W'(1);
   endfunction

endpackage

FILE: rtl/core/plfr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data and read enable. No dependencies.
module plfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/preamble_length_frame_receiver_top.sv
// Top level of the preamble/length frame receiver.
// Depends on plfr_pkg and plfr_ram.

// One transaction is accepted per clock while results are taken, and each
// yields exactly one result via the input register, then the result register;
// the frame store RAM's registered read port loads with it. Results may be
// held back by rsp_tready; one further transaction is still taken while a
// result waits. Action 0 feeds a serial byte through preamble, length and body
// matching, action 1 releases the oldest frame, action 2 reads one byte of it.
module preamble_length_frame_receiver_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // rx_byte[7:0], read_offset[15:8]
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // status[2:0], read_data[10:3],
                                   // oldest_length[18:11], queue_empty[19]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   // configuration
   logic [7:0] preamble_char_ff;
   logic [7:0] end_char_ff;

   // input register
   logic                     s1_valid_ff;
   plfr_pkg::action_type     s1_action_ff;
   logic [7:0]               s1_byte_ff;
   logic [plfr_pkg::OFFS_W-1:0] s1_offset_ff;

   // result register
   logic                     s2_valid_ff;
   plfr_pkg::status_type     s2_status_ff;
   logic [7:0]               s2_length_ff;
   logic                     s2_empty_ff;
   logic                     s2_rd_ff;

   // receiver state
   logic [plfr_pkg::MATCH_W-1:0] match_ff, match_in;
   logic [7:0]                   frame_len_ff, frame_len_in;
   logic [plfr_pkg::OFFS_W-1:0]  taken_ff, taken_in;
   logic [plfr_pkg::SLOT_W-1:0]  wr_slot_ff, wr_slot_in;
   logic [plfr_pkg::SLOT_W-1:0]  head_ff, head_in;
   logic [7:0]                   slot_len_ff [plfr_pkg::SLOT_COUNT];

   logic                 advance;
   logic                 step;
   plfr_pkg::status_type status_in;
   logic                 store_we;
   logic                 len_we;
   logic                 rd_en;
   logic                 empty_in;
   logic [7:0]           length_in;
   logic [7:0]           ram_q;

   assign advance    = !s2_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      match_in     = match_ff;
      frame_len_in = frame_len_ff;
      taken_in     = taken_ff;
      wr_slot_in   = wr_slot_ff;
      head_in      = head_ff;
      status_in    = plfr_pkg::ST_IDLE;
      store_we     = 1'b0;
      len_we       = 1'b0;
      rd_en        = 1'b0;
      unique case (s1_action_ff)
         plfr_pkg::ACT_RECEIVE: begin
            if (match_ff < plfr_pkg::MATCH_LEN) begin
               if (s1_byte_ff == preamble_char_ff) begin
                  match_in  = match_ff + plfr_pkg::MATCH_W'(1);
                  status_in = plfr_pkg::ST_INCOMING;
               end else begin
                  match_in  = '0;
                  status_in = plfr_pkg::ST_ERROR;
               end
            end else if (match_ff == plfr_pkg::MATCH_LEN) begin
               frame_len_in = s1_byte_ff;
               taken_in     = '0;
               match_in     = plfr_pkg::MATCH_BODY;
               status_in    = plfr_pkg::ST_INCOMING;
            end else begin
               store_we = 1'b1;
               if (taken_ff != frame_len_ff) begin
                  taken_in = taken_ff + plfr_pkg::OFFS_W'(1);
               end else begin
                  match_in = '0;
                  taken_in = '0;
                  if (s1_byte_ff != end_char_ff) begin
                     status_in = plfr_pkg::ST_ERROR;
                  end else begin
                     len_we       = 1'b1;
                     frame_len_in = '0;
                     wr_slot_in   = plfr_pkg::next_slot(wr_slot_ff);
                     status_in    = (wr_slot_in == head_ff) ? plfr_pkg::ST_FULL
                                                            : plfr_pkg::ST_NEW;
                  end
               end
            end
         end
         plfr_pkg::ACT_RELEASE: begin
            if (wr_slot_ff != head_ff) begin
               head_in = plfr_pkg::next_slot(head_ff);
            end
         end
         plfr_pkg::ACT_READ: begin
            rd_en = (wr_slot_ff != head_ff);
         end
         default: begin
         end
      endcase
      empty_in = (wr_slot_in == head_in);
      if (empty_in) begin
         length_in = '0;
      end else if (len_we && wr_slot_ff == head_in) begin
         length_in = frame_len_ff;
      end else begin
         length_in = slot_len_ff[head_in];
      end
   end

   plfr_ram #(
      .WIDTH(8),
      .DEPTH(plfr_pkg::STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (step && store_we),
      .wr_addr({wr_slot_ff, taken_ff}),
      .wr_data(s1_byte_ff),
      .rd_en  (step && rd_en),
      .rd_addr({head_ff, s1_offset_ff}),
      .rd_data(ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_char_ff <= plfr_pkg::PREAMBLE_RESET;
         end_char_ff      <= plfr_pkg::END_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            plfr_pkg::CSR_PREAMBLE: preamble_char_ff <= csr_wdata;
            plfr_pkg::CSR_END:      end_char_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         match_ff    <= '0;
         frame_len_ff <= '0;
         taken_ff    <= '0;
         wr_slot_ff  <= '0;
         head_ff     <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (step) begin
            match_ff     <= match_in;
            frame_len_ff <= frame_len_in;
            taken_ff     <= taken_in;
            wr_slot_ff   <= wr_slot_in;
            head_ff      <= head_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_action_ff <= plfr_pkg::action_type'(req_tuser);
         s1_byte_ff   <= req_tdata[7:0];
         s1_offset_ff <= req_tdata[15:8];
      end
      if (step) begin
         s2_status_ff <= status_in;
         s2_length_ff <= length_in;
         s2_empty_ff  <= empty_in;
         s2_rd_ff     <= rd_en;
         if (len_we) begin
            slot_len_ff[wr_slot_ff] <= frame_len_ff;
         end
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {4'b0, s2_empty_ff, s2_length_ff,
                        (s2_rd_ff ? ram_q : 8'd0), s2_status_ff};

   a_match_range: assert property (@(posedge clock) disable iff (reset)
      match_ff <= plfr_pkg::MATCH_BODY)
      else $error("match counter out of range");

   a_taken_body: assert property (@(posedge clock) disable iff (reset)
      taken_ff != '0 |-> match_ff == plfr_pkg::MATCH_BODY)
      else $error("body count outside body phase");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[19] |-> rsp_tdata[18:3] == 16'd0)
      else $error("empty queue reports frame data");

   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      step && len_we |=> wr_slot_ff != $past(wr_slot_ff))
      else $error("accepted frame did not advance write slot");

endmodule

FILE: test/preamble_length_frame_receiver_tb.sv
// Testbench for preamble_length_frame_receiver_top: framed serial byte streams, oldest-frame
// reads and releases, random stalls on both stream sides, CSR changes between phases.
// Depends on plfr_pkg and the receiver RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int LIMIT_CYCLES = 500000;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic                 queue_empty;
      logic [7:0]           oldest_length;
      logic [7:0]           read_data;
      plfr_pkg::status_type status;
   } rsp_fields_type;

   class frame_ring_scoreboard;
      logic [7:0]                   preamble_byte;
      logic [7:0]                   end_mark;
      logic [plfr_pkg::MATCH_W-1:0] phase;
      logic [7:0]                   frame_len;
      logic [8:0]                   taken;
      bit [7:0]                     store [plfr_pkg::STORE_DEPTH];
      bit                           written [plfr_pkg::STORE_DEPTH];
      bit [7:0]                     slot_len [plfr_pkg::SLOT_COUNT];
      logic [plfr_pkg::SLOT_W-1:0]  wr_slot;
      logic [plfr_pkg::SLOT_W-1:0]  hd_slot;
      rsp_fields_type               awaited_rsp [$];
      int                           errors;

      function new();
         preamble_byte = plfr_pkg::PREAMBLE_RESET;
         end_mark      = plfr_pkg::END_RESET;
         phase         = '0;
         frame_len     = '0;
         taken         = '0;
         wr_slot       = '0;
         hd_slot       = '0;
         errors        = 0;
      endfunction

      function void write_reg(logic idx, logic [7:0] value);
         if (idx == plfr_pkg::CSR_PREAMBLE) begin
            preamble_byte = value;
         end else begin
            end_mark = value;
         end
      endfunction

      function logic [plfr_pkg::SLOT_W-1:0] advance(logic [plfr_pkg::SLOT_W-1:0] s);
         return (s == plfr_pkg::SLOT_W'(plfr_pkg::SLOT_COUNT - 1)) ? '0
                                                                   : s + plfr_pkg::SLOT_W'(1);
      endfunction

      function plfr_pkg::status_type take_serial_byte(logic [7:0] b);
         int addr;
         if (phase < plfr_pkg::MATCH_LEN) begin
            if (b == preamble_byte) begin
               phase++;
               return plfr_pkg::ST_INCOMING;
            end
            phase = '0;
            return plfr_pkg::ST_ERROR;
         end
         if (phase == plfr_pkg::MATCH_LEN) begin
            frame_len = b;
            taken     = '0;
            phase     = plfr_pkg::MATCH_BODY;
            return plfr_pkg::ST_INCOMING;
         end
         if (taken < plfr_pkg::SLOT_BYTES) begin
            addr = int'(wr_slot) * plfr_pkg::SLOT_BYTES + int'(taken);
            store[addr]   = b;
            written[addr] = 1'b1;
         end
         taken++;
         if (taken < {1'b0, frame_len} + 9'd1) begin
            return plfr_pkg::ST_IDLE;
         end
         phase = '0;
         taken = '0;
         if (store[int'(wr_slot) * plfr_pkg::SLOT_BYTES + int'(frame_len)] != end_mark) begin
            return plfr_pkg::ST_ERROR;
         end
         slot_len[wr_slot] = frame_len;
         frame_len = '0;
         wr_slot   = advance(wr_slot);
         return (wr_slot == hd_slot) ? plfr_pkg::ST_FULL : plfr_pkg::ST_NEW;
      endfunction

      function void note_transaction(plfr_pkg::action_type act, logic [7:0] rx,
                                     logic [7:0] offs);
         rsp_fields_type r;
         r = '0;
         r.status = plfr_pkg::ST_IDLE;
         case (act)
            plfr_pkg::ACT_RECEIVE: r.status = take_serial_byte(rx);
            plfr_pkg::ACT_RELEASE: begin
               if (wr_slot != hd_slot) hd_slot = advance(hd_slot);
            end
            plfr_pkg::ACT_READ: begin
               if (wr_slot != hd_slot) begin
                  r.read_data = store[int'(hd_slot) * plfr_pkg::SLOT_BYTES + int'(offs)];
               end
            end
            default: ;
         endcase
         r.queue_empty   = (wr_slot == hd_slot);
         r.oldest_length = r.queue_empty ? 8'd0 : slot_len[hd_slot];
         awaited_rsp.push_back(r);
      endfunction

      function void check_response(logic [23:0] bits);
         rsp_fields_type want;
         rsp_fields_type got;
         if (awaited_rsp.size() == 0) begin
            $error("response 0x%06h arrived with none outstanding", bits);
            errors++;
            return;
         end
         want = awaited_rsp.pop_front();
         got  = rsp_fields_type'(bits[19:0]);
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
            errors++;
         end
         if (got.oldest_length !== want.oldest_length) begin
            $error("oldest_length: expected %0d, got %0d", want.oldest_length,
                   got.oldest_length);
            errors++;
         end
         if (got.queue_empty !== want.queue_empty) begin
            $error("queue_empty: expected %0d, got %0d", want.queue_empty, got.queue_empty);
            errors++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // rx_byte[7:0], read_offset[15:8]
   logic [1:0]  req_tuser  = '0;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // status[2:0], read_data[10:3],
                                   // oldest_length[18:11], queue_empty[19]
   logic        csr_we     = 1'b0;
   logic        csr_index  = 1'b0;
   logic [7:0]  csr_wdata  = '0;

   frame_ring_scoreboard sb;
   int max_gap       = 13;
   int items_sent    = 0;
   int results_taken = 0;
   int cycle_count   = 0;

   preamble_length_frame_receiver_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_item(plfr_pkg::action_type act, logic [7:0] rx, logic [7:0] offs);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {offs, rx};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      sb.note_transaction(act, rx, offs);
      if (act != plfr_pkg::ACT_NONE) items_sent++;
   endtask

   task automatic send_frame(int len, bit good_end, bit broken);
      int bad_pos;
      bad_pos = broken ? $urandom_range(0, plfr_pkg::PREAMBLE_BYTES - 1) : -1;
      for (int i = 0; i < plfr_pkg::PREAMBLE_BYTES; i++) begin
         send_item(plfr_pkg::ACT_RECEIVE,
                   (i == bad_pos) ? sb.preamble_byte ^ 8'($urandom_range(1, 255))
                                  : sb.preamble_byte, any_byte());
      end
      send_item(plfr_pkg::ACT_RECEIVE, 8'(len), any_byte());
      for (int i = 0; i < len; i++) begin
         send_item(plfr_pkg::ACT_RECEIVE, any_byte(), any_byte());
      end
      send_item(plfr_pkg::ACT_RECEIVE,
                good_end ? sb.end_mark : sb.end_mark ^ 8'($urandom_range(1, 255)),
                any_byte());
   endtask

   // only offsets that some frame has already stored are read
   task automatic read_oldest();
      logic [7:0] offs;
      int base;
      offs = any_byte();
      if (sb.wr_slot != sb.hd_slot) begin
         base = int'(sb.hd_slot) * plfr_pkg::SLOT_BYTES;
         if ($urandom_range(0, 3) == 0) begin
            offs = sb.slot_len[sb.hd_slot];
         end else if (!sb.written[base + int'(offs)]) begin
            offs = 8'($urandom_range(0, int'(sb.slot_len[sb.hd_slot])));
         end
      end
      send_item(plfr_pkg::ACT_READ, any_byte(), offs);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   task automatic run_phase(int count, int release_pct);
      int target;
      int pick;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(0, 19) == 0) max_gap = (max_gap == 0) ? 13 : 0;
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_frame(($urandom_range(0, 149) == 0) ? 255 : $urandom_range(0, 12),
                       $urandom_range(0, 9) != 0, $urandom_range(0, 14) == 0);
         end else if (pick < 50 + release_pct) begin
            send_item(plfr_pkg::ACT_RELEASE, any_byte(), any_byte());
         end else if (pick < 80) begin
            read_oldest();
         end else if (pick < 95) begin
            send_item(plfr_pkg::ACT_RECEIVE, any_byte(), any_byte());
         end else begin
            send_item(plfr_pkg::ACT_NONE, any_byte(), any_byte());
         end
      end
      max_gap = 13;
   endtask

   // response side: random stalls, one long hold-off to back up the input
   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = (results_taken == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, max_gap);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata);
         results_taken++;
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("preamble_length_frame_receiver_top test failed");
      $finish;
   end

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, unused action, bad preamble, short frames
      send_item(plfr_pkg::ACT_RELEASE, 8'h00, 8'h00);
      send_item(plfr_pkg::ACT_READ, 8'hFF, 8'hFF);
      send_item(plfr_pkg::ACT_NONE, 8'hFF, 8'hFF);
      send_item(plfr_pkg::ACT_RECEIVE, 8'h00, 8'h00);
      send_item(plfr_pkg::ACT_RECEIVE, 8'hFF, 8'hFF);
      send_frame(0, 1'b1, 1'b0);
      send_item(plfr_pkg::ACT_READ, 8'h00, 8'h00);
      send_frame(1, 1'b0, 1'b0);
      send_item(plfr_pkg::ACT_RECEIVE, sb.preamble_byte, 8'h00);
      send_item(plfr_pkg::ACT_RECEIVE, sb.preamble_byte, 8'h00);
      send_item(plfr_pkg::ACT_RECEIVE, 8'h00, 8'h00);
      send_item(plfr_pkg::ACT_RELEASE, 8'hFF, 8'h00);

      write_csr(plfr_pkg::CSR_PREAMBLE, 8'h00);
      write_csr(plfr_pkg::CSR_END, 8'hFF);
      run_phase(280, 10);

      write_csr(plfr_pkg::CSR_PREAMBLE, 8'hFF);
      write_csr(plfr_pkg::CSR_END, 8'h00);
      while (sb.wr_slot != sb.hd_slot) begin
         send_item(plfr_pkg::ACT_RELEASE, any_byte(), any_byte());
      end
      send_frame(255, 1'b1, 1'b0);
      send_item(plfr_pkg::ACT_READ, any_byte(), 8'hFF);
      run_phase(280, 25);

      write_csr(plfr_pkg::CSR_PREAMBLE, any_byte());
      write_csr(plfr_pkg::CSR_END, any_byte());
      run_phase(280, 15);

      write_csr(plfr_pkg::CSR_PREAMBLE, plfr_pkg::PREAMBLE_RESET);
      write_csr(plfr_pkg::CSR_END, plfr_pkg::END_RESET);
      run_phase(280, 10);

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("preamble_length_frame_receiver_top test passed");
      end else begin
         $display("preamble_length_frame_receiver_top test failed");
      end
      $finish;
   end

endmodule
